>>> hw/rtl/plist_pkg.sv
`default_nettype none

package plist_pkg;

  // widest position or length any configuration can reach (capacity up to 64)
  localparam int unsigned PosW = 7;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_DUMP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t        op;
    logic [PosW-1:0] pos;
    logic [PosW-1:0] count;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/plist_if.sv
`default_nettype none

interface plist_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] value;
  logic [5:0]         position;

  modport source (output valid, output cmd, output value, output position, input ready);
  modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface plist_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] element;
  logic               last;
  logic [5:0]         count;

  modport source (output valid, output status, output element, output last, output count,
                  input ready);
  modport sink   (input valid, input status, input element, input last, input count,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/plist_cell.sv
`default_nettype none

module plist_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  wire logic                        clk,
  input  wire plist_pkg::cell_ctl_t        ctl,
  input  wire logic [DATA_WIDTH-1:0]       value_in,
  input  wire logic [DATA_WIDTH-1:0]       left,
  input  wire logic [DATA_WIDTH-1:0]       right,
  input  wire logic [DATA_WIDTH-1:0]       tail,
  output logic      [DATA_WIDTH-1:0]       q,
  output logic      [DATA_WIDTH-1:0]       tap
);

  localparam logic [plist_pkg::PosW-1:0] Idx = plist_pkg::PosW'(INDEX);

  logic [DATA_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctl.op)
      plist_pkg::OP_HOLD: begin
        q_next = q;
      end
      plist_pkg::OP_INSERT: begin
        if (Idx == ctl.pos) begin
          q_next = value_in;
        end else if (Idx > ctl.pos && Idx <= ctl.count) begin
          q_next = left;
        end
      end
      plist_pkg::OP_REMOVE: begin
        if (Idx >= ctl.pos && (Idx + 1'b1) < ctl.count) begin
          q_next = right;
        end
      end
      plist_pkg::OP_ROTATE: begin
        // live part of the row turns by one, tail wraps to the head
        if (Idx == '0) begin
          q_next = tail;
        end else if (Idx < ctl.count) begin
          q_next = left;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // only the tail cell drives the shared read bus
  assign tap = ((Idx + 1'b1) == ctl.count) ? q : '0;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_insert_delete.sv
// channel | dir | fields                          | note
// req     | in  | cmd, value, position            | one transfer per command
// rsp     | out | status, element, last, count    | one per edit, one per entry on dump
//
// append, insert and remove finish in the cycle they are taken: the whole cell row
// shifts at once, so an edit can follow every cycle while the response is drained
// a dump first enters the dump state, then sends the entries one by one as the
// response register frees (an empty list gets a single empty status); the row turns
// by one place per entry sent and the tail cell drives the output, so after length
// steps the list is back in order; no command is taken during a dump
// synchronous active-high reset empties the list; cell contents are not cleared
// a stalled response holds its register, the request side waits until it frees
`default_nettype none

module positional_list_insert_delete #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned DATA_WIDTH = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  plist_req_if.sink  req,
  plist_rsp_if.source rsp
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] Full = CntW'(CAPACITY);

  // row of cells
  logic [DATA_WIDTH-1:0] cell_q   [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_tap [CAPACITY];
  logic [DATA_WIDTH-1:0] tail;
  logic [DATA_WIDTH-1:0] value_in;
  plist_pkg::cell_ctl_t  ctl;

  // control
  plist_pkg::state_t state, state_next;
  logic [CntW-1:0]   count, count_next;
  logic [CntW-1:0]   remain, remain_next;

  // response register
  logic                 rsp_valid;
  plist_pkg::status_t   rsp_status;
  logic signed [31:0]   rsp_element;
  logic                 rsp_last;
  logic [5:0]           rsp_count;

  logic                 load;
  plist_pkg::status_t   ld_status;
  logic signed [31:0]   ld_element;
  logic                 ld_last;
  logic                 take;
  logic [plist_pkg::PosW-1:0] pos_w;
  logic [plist_pkg::PosW-1:0] count_w;

  // low bits of the signed request value are kept (sign-extended for wide data)
  assign value_in = DATA_WIDTH'(req.value);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left;
      logic [DATA_WIDTH-1:0] right;
      if (g == 0) begin : g_first
        assign left = '0;
      end else begin : g_mid_l
        assign left = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right = '0;
      end else begin : g_mid_r
        assign right = cell_q[g+1];
      end
      plist_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX      (g)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .value_in (value_in),
        .left     (left),
        .right    (right),
        .tail     (tail),
        .q        (cell_q[g]),
        .tap      (cell_tap[g])
      );
    end
  endgenerate

  // tail read bus: at most one cell drives non-zero
  always_comb begin
    tail = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tail = tail | cell_tap[i];
    end
  end

  assign take    = !rsp_valid || rsp.ready;
  assign req.ready = (state == plist_pkg::S_IDLE) && take;
  assign pos_w   = plist_pkg::PosW'(req.position);
  assign count_w = plist_pkg::PosW'(count);

  always_comb begin
    state_next  = state;
    count_next  = count;
    remain_next = remain;
    ctl.op      = plist_pkg::OP_HOLD;
    ctl.pos     = pos_w;
    ctl.count   = count_w;
    load        = 1'b0;
    ld_status   = plist_pkg::ST_OK;
    ld_element  = '0;
    ld_last     = 1'b1;
    unique case (state)
      plist_pkg::S_IDLE: begin
        if (req.valid && req.ready) begin
          load = 1'b1;
          unique case (plist_pkg::cmd_t'(req.cmd))
            plist_pkg::CMD_APPEND: begin
              if (count == Full) begin
                ld_status = plist_pkg::ST_FULL;
              end else begin
                // append is an insert at the tail position
                ctl.op     = plist_pkg::OP_INSERT;
                ctl.pos    = count_w;
                count_next = count + 1'b1;
              end
            end
            plist_pkg::CMD_INSERT: begin
              // range is checked before fullness
              priority if (pos_w > count_w) begin
                ld_status = plist_pkg::ST_RANGE;
              end else if (count == Full) begin
                ld_status = plist_pkg::ST_FULL;
              end else begin
                ctl.op     = plist_pkg::OP_INSERT;
                count_next = count + 1'b1;
              end
            end
            plist_pkg::CMD_REMOVE: begin
              priority if (count == '0) begin
                ld_status = plist_pkg::ST_EMPTY;
              end else if (pos_w >= count_w) begin
                ld_status = plist_pkg::ST_RANGE;
              end else begin
                ctl.op     = plist_pkg::OP_REMOVE;
                count_next = count - 1'b1;
              end
            end
            plist_pkg::CMD_DUMP: begin
              if (count == '0) begin
                ld_status = plist_pkg::ST_EMPTY;
              end else begin
                // entries go out from the dump state
                load        = 1'b0;
                remain_next = count;
                state_next  = plist_pkg::S_DUMP;
              end
            end
            default: ld_status = plist_pkg::ST_OK;
          endcase
        end
      end
      plist_pkg::S_DUMP: begin
        if (take) begin
          load        = 1'b1;
          ld_element  = 32'($signed(tail));
          ld_last     = (remain == CntW'(1));
          ctl.op      = plist_pkg::OP_ROTATE;
          remain_next = remain - 1'b1;
          if (remain == CntW'(1)) begin
            state_next = plist_pkg::S_IDLE;
          end
        end
      end
      default: state_next = plist_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= plist_pkg::S_IDLE;
      count  <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
    end
  end

  // output register parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_status  <= ld_status;
      rsp_element <= ld_element;
      rsp_last    <= ld_last;
      rsp_count   <= 6'(count_next);
    end
  end

  assign rsp.valid   = rsp_valid;
  assign rsp.status  = rsp_status;
  assign rsp.element = rsp_element;
  assign rsp.last    = rsp_last;
  assign rsp.count   = rsp_count;

endmodule

`default_nettype wire

>>> hw/rtl/plist_checker.sv
`default_nettype none

module plist_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic [1:0]  req_cmd,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  rsp_status,
  input wire logic [31:0] rsp_element,
  input wire logic        rsp_last,
  input wire logic [5:0]  rsp_count
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_element) && $stable(rsp_last) && $stable(rsp_count))
    else $error("response changed while stalled");

  // an edit answers in the next cycle with a single closing response
  a_edit_rsp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd != plist_pkg::CMD_DUMP |=>
      rsp_valid && rsp_last && rsp_element == '0)
    else $error("edit did not give one closing response");

  // error codes never appear mid-dump
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != plist_pkg::ST_OK |-> rsp_last)
    else $error("error status on a non-final response");

  // no new command while a dump is still going out
  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> !req_ready)
    else $error("command taken during dump");

  // empty dump answers next cycle, a non-empty one the cycle after
  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_cmd == plist_pkg::CMD_DUMP |-> ##[1:2] rsp_valid)
    else $error("dump produced no response");

endmodule

bind positional_list_insert_delete plist_checker u_plist_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_cmd     (req.cmd),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_element (rsp.element),
  .rsp_last    (rsp.last),
  .rsp_count   (rsp.count)
);

`default_nettype wire

>>> dv/tb_positional_list_insert_delete.sv
module tb_positional_list_insert_delete;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_CAP   = 32;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned RAND_CMDS  = 475;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned LONG_HOLD  = 150;

  // one command waiting to be offered, with the idle cycles that go before it
  typedef struct {
    plist_pkg::cmd_t    op;
    logic signed [31:0] value;
    logic [5:0]         position;
    int unsigned        gap;
  } list_cmd_t;

  // one response as the list should give it
  typedef struct {
    plist_pkg::status_t status;
    logic signed [31:0] element;
    logic               last;
    logic [5:0]         count;
  } list_rsp_t;

  // steers the random commands so the list swings between empty and full
  typedef enum {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } mix_phase_t;

  logic clk = 1'b0;
  logic rst;

  plist_req_if req_ch ();
  plist_rsp_if rsp_ch ();

  positional_list_insert_delete #(
    .CAPACITY   (LIST_CAP),
    .DATA_WIDTH (DATA_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // commands still to be offered, and the responses the list owes us
  list_cmd_t   cmd_pending_q[$];
  list_rsp_t   expected_rsp_q[$];

  // our own copy of the list contents, head at index 0
  logic signed [31:0] list_model[$];

  // length as the generator expects it, so positions can be aimed
  int unsigned gen_len;
  bit          send_eager;

  // set at the rising edge when a transfer happens, used at the next falling edge
  bit          req_taken;
  bit          rsp_taken;
  int unsigned rsp_seen;
  int unsigned err_count;

  // sender state
  list_cmd_t   cur_cmd;
  bit          cmd_loaded;
  int unsigned cmd_gap;

  // receiver state
  int unsigned rsp_wait;
  int unsigned rsp_hold;
  bit          rsp_eager;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // work out every response one accepted command should produce
  function automatic void predict_list_response(plist_pkg::cmd_t op,
                                                logic signed [31:0] val,
                                                logic [5:0] pos);
    list_rsp_t          r;
    logic signed [31:0] kept;
    int unsigned        len;
    len       = list_model.size();
    // only the low data-width bits are stored, sign-extended again on the way out
    kept      = val <<< (32 - DATA_W);
    kept      = kept >>> (32 - DATA_W);
    r.status  = plist_pkg::ST_OK;
    r.element = '0;
    r.last    = 1'b1;
    case (op)
      plist_pkg::CMD_DUMP: begin
        // tail first, last flag only on the head entry
        if (len == 0) begin
          r.status = plist_pkg::ST_EMPTY;
          r.count  = '0;
          expected_rsp_q.push_back(r);
        end else begin
          for (int i = len; i > 0; i--) begin
            r.element = list_model[i-1];
            r.last    = (i == 1);
            r.count   = 6'(len);
            expected_rsp_q.push_back(r);
          end
        end
        return;
      end
      plist_pkg::CMD_APPEND: begin
        if (len >= LIST_CAP) r.status = plist_pkg::ST_FULL;
        else list_model.push_back(kept);
      end
      plist_pkg::CMD_INSERT: begin
        // range is checked before fullness
        if (pos > len) r.status = plist_pkg::ST_RANGE;
        else if (len >= LIST_CAP) r.status = plist_pkg::ST_FULL;
        else list_model.insert(int'(pos), kept);
      end
      plist_pkg::CMD_REMOVE: begin
        if (len == 0) r.status = plist_pkg::ST_EMPTY;
        else if (pos >= len) r.status = plist_pkg::ST_RANGE;
        else list_model.delete(int'(pos));
      end
    endcase
    r.count = 6'(list_model.size());
    expected_rsp_q.push_back(r);
  endfunction

  // queue a command, draw its idle gap and track the length it should leave
  task automatic queue_command(plist_pkg::cmd_t op, logic [31:0] val, logic [5:0] pos);
    list_cmd_t c;
    c.op       = op;
    c.value    = val;
    c.position = pos;
    // now and then switch between back-to-back offers and random gaps
    if ($urandom_range(0, 29) == 0) send_eager = !send_eager;
    c.gap = send_eager ? 0 : $urandom_range(0, 14);
    case (op)
      plist_pkg::CMD_APPEND: if (gen_len < LIST_CAP) gen_len++;
      plist_pkg::CMD_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
      plist_pkg::CMD_REMOVE: if (gen_len > 0 && pos < gen_len) gen_len--;
      default: ;
    endcase
    cmd_pending_q.push_back(c);
  endtask

  task automatic flag_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    err_count++;
  endtask

  // monitor: requests are predicted before responses are checked, so a response
  // landing on the same edge as its own command still finds its expectation
  always @(posedge clk) begin
    list_rsp_t exp_rsp;
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        req_taken = 1'b1;
        predict_list_response(plist_pkg::cmd_t'(req_ch.cmd), req_ch.value,
                              req_ch.position);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_taken = 1'b1;
        rsp_seen++;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: unexpected response, status %0d element %0d last %0d count %0d",
                   $time, rsp_ch.status, rsp_ch.element, rsp_ch.last, rsp_ch.count);
          err_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_ch.status !== exp_rsp.status)
            flag_mismatch("status", exp_rsp.status, rsp_ch.status);
          if (rsp_ch.element !== exp_rsp.element)
            flag_mismatch("element", exp_rsp.element, rsp_ch.element);
          if (rsp_ch.last !== exp_rsp.last)
            flag_mismatch("last", exp_rsp.last, rsp_ch.last);
          if (rsp_ch.count !== exp_rsp.count)
            flag_mismatch("count", exp_rsp.count, rsp_ch.count);
        end
      end
    end
  end

  // driver: pulls commands off the pending queue, idles for the drawn gap,
  // then holds valid until the transfer goes through
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) cmd_loaded = 1'b0;
      if (!cmd_loaded && cmd_pending_q.size() != 0) begin
        cur_cmd    = cmd_pending_q.pop_front();
        cmd_loaded = 1'b1;
        cmd_gap    = cur_cmd.gap;
      end
      if (cmd_loaded && cmd_gap != 0) begin
        cmd_gap--;
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid <= cmd_loaded;
      end
      if (cmd_loaded) begin
        req_ch.cmd      <= cur_cmd.op;
        req_ch.value    <= cur_cmd.value;
        req_ch.position <= cur_cmd.position;
      end
    end
  end

  // receiver: random stall before each response, with eager stretches, and two
  // long hold-offs so the response register fills and the request side backs up
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_taken) begin
        if (rsp_seen == 50 || rsp_seen == 400) rsp_hold = LONG_HOLD;
        if ($urandom_range(0, 39) == 0) rsp_eager = !rsp_eager;
        rsp_wait = rsp_eager ? 0 : $urandom_range(0, 14);
      end
      if (rsp_hold != 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_wait != 0) begin
        rsp_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus and end of run
  initial begin
    mix_phase_t      phase;
    plist_pkg::cmd_t op;
    logic [31:0]     val;
    logic [5:0]      pos;
    int unsigned     roll;
    int unsigned     pick;

    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.cmd      = plist_pkg::CMD_APPEND;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
    gen_len         = 0;
    send_eager      = 1'b0;
    rsp_eager       = 1'b0;
    rsp_wait        = 0;
    rsp_hold        = 0;
    rsp_seen        = 0;
    err_count       = 0;
    cmd_loaded      = 1'b0;
    cmd_gap         = 0;

    // directed: empty list cases first
    queue_command(plist_pkg::CMD_DUMP,   32'h0, 6'd0);
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd0);
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd63);
    queue_command(plist_pkg::CMD_INSERT, 32'h1234_5678, 6'd1);
    // build a short list from the value extremes
    queue_command(plist_pkg::CMD_INSERT, 32'h7FFF_FFFF, 6'd0);
    queue_command(plist_pkg::CMD_APPEND, 32'h8000_0000, 6'd0);
    queue_command(plist_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd0);
    queue_command(plist_pkg::CMD_APPEND, 32'h0000_0000, 6'd0);
    queue_command(plist_pkg::CMD_INSERT, 32'h5555_5555, 6'd2);
    // insert exactly at the length, then well past it
    queue_command(plist_pkg::CMD_INSERT, 32'hAAAA_AAAA, 6'd5);
    queue_command(plist_pkg::CMD_INSERT, 32'h0F0F_0F0F, 6'd63);
    // remove at the length and beyond
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd6);
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd63);
    queue_command(plist_pkg::CMD_DUMP,   32'h0, 6'd0);
    // remove head, tail and a middle entry
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd0);
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd4);
    queue_command(plist_pkg::CMD_REMOVE, 32'h0, 6'd2);
    queue_command(plist_pkg::CMD_DUMP,   32'hFFFF_FFFF, 6'd63);
    // position is don't-care on append
    queue_command(plist_pkg::CMD_APPEND, 32'h0000_0001, 6'd63);
    queue_command(plist_pkg::CMD_DUMP,   32'h0, 6'd0);

    // random part: fill to capacity, hammer it while full, drain to empty
    phase = PH_FILL;
    repeat (RAND_CMDS) begin
      if (gen_len == LIST_CAP && $urandom_range(0, 7) == 0) phase = PH_DRAIN;
      else if (gen_len == 0 && $urandom_range(0, 2) == 0) phase = PH_FILL;
      else if ($urandom_range(0, 59) == 0) phase = PH_MIXED;

      roll = $urandom_range(0, 99);
      case (phase)
        PH_FILL:  op = (roll < 45) ? plist_pkg::CMD_APPEND :
                       (roll < 85) ? plist_pkg::CMD_INSERT :
                       (roll < 95) ? plist_pkg::CMD_REMOVE : plist_pkg::CMD_DUMP;
        PH_DRAIN: op = (roll < 10) ? plist_pkg::CMD_APPEND :
                       (roll < 25) ? plist_pkg::CMD_INSERT :
                       (roll < 88) ? plist_pkg::CMD_REMOVE : plist_pkg::CMD_DUMP;
        default:  op = (roll < 25) ? plist_pkg::CMD_APPEND :
                       (roll < 50) ? plist_pkg::CMD_INSERT :
                       (roll < 85) ? plist_pkg::CMD_REMOVE : plist_pkg::CMD_DUMP;
      endcase

      // mostly a valid position, sometimes just past the end, sometimes anything
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        if (op == plist_pkg::CMD_REMOVE)
          pos = (gen_len == 0) ? 6'd0 : 6'($urandom_range(0, gen_len - 1));
        else pos = 6'($urandom_range(0, gen_len));
      end else if (pick == 8) begin
        pos = (op == plist_pkg::CMD_REMOVE) ? 6'(gen_len) : 6'(gen_len + 1);
      end else begin
        pos = 6'($urandom_range(0, 63));
      end

      pick = $urandom_range(0, 15);
      case (pick)
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'hFFFF_FFFF;
        3:       val = 32'h0000_0000;
        default: val = $urandom;
      endcase

      queue_command(op, val, pos);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for every command to go across, then for the responses to drain
    while (cmd_pending_q.size() != 0 || cmd_loaded) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    // then keep watching to catch anything the block sends uninvited
    repeat (DRAIN_WAIT) @(posedge clk);

    if (expected_rsp_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, expected_rsp_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("tb_positional_list_insert_delete: done, clean");
    end else begin
      $display("tb_positional_list_insert_delete: done, errors");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #15_000_000;
    $display("%0t: timeout", $time);
    $display("tb_positional_list_insert_delete: done, errors");
    $finish;
  end

endmodule
